### sv/radial_farthest_edge_search_core_macros.svh
// Assertion helpers for the RTL core file; clocked on clk, disabled in reset.
`ifndef RADIAL_FARTHEST_EDGE_SEARCH_CORE_MACROS_SVH
`define RADIAL_FARTHEST_EDGE_SEARCH_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define RFES_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define RFES_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RFES_ASSERT_IMP(lbl, ante, cons, msg)
`define RFES_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

### sv/rfes_pkg.sv
package rfes_pkg;

    localparam int IMAGE_WIDTH    = 188;
    localparam int IMAGE_HEIGHT   = 120;
    localparam int ANGLE_STEP_DEG = 10;

    localparam int FRAC_BITS = 14;
    localparam int ONE_Q     = 1 << FRAC_BITS;

    localparam int PIX_TOTAL = IMAGE_WIDTH * IMAGE_HEIGHT;
    localparam int ADDR_W    = $clog2(PIX_TOTAL);
    localparam int CNT_W     = $clog2(PIX_TOTAL + 1);

    localparam int ROW_W      = $clog2(IMAGE_HEIGHT);
    localparam int COL_W      = $clog2(IMAGE_WIDTH);
    localparam int MAG_W      = (ROW_W > COL_W) ? ROW_W : COL_W;
    localparam int SQ_W       = 2 * MAG_W + 1;
    localparam int DIST_OUT_W = 14;

    localparam int CX = IMAGE_WIDTH / 2;
    localparam int CY = IMAGE_HEIGHT / 2;

    localparam int SD_W = 8;
    localparam logic [SD_W-1:0] SD_RESET = SD_W'(50);

    localparam int DEG_FULL    = 360;
    localparam int DEG_QUARTER = 90;
    localparam int DEG_W       = $clog2(DEG_FULL + DEG_QUARTER);
    localparam int QIDX_W      = $clog2(DEG_QUARTER + 1);

    // Direction is Q2.14, position Q.14 with room for centre plus longest jump
    localparam int DIR_W   = FRAC_BITS + 2;
    localparam int Q_W     = FRAC_BITS + 1;
    localparam int MAX_DIM = (IMAGE_WIDTH > IMAGE_HEIGHT) ? IMAGE_WIDTH : IMAGE_HEIGHT;
    localparam int IP_W    = $clog2(MAX_DIM + (1 << SD_W) + 2) + 1;
    localparam int POS_W   = IP_W + FRAC_BITS;

    localparam logic signed [POS_W-1:0] CX_Q      = POS_W'(CX * ONE_Q);
    localparam logic signed [POS_W-1:0] CY_Q      = POS_W'(CY * ONE_Q);
    localparam logic signed [POS_W-1:0] NEG_LIMIT = POS_W'(-ONE_Q);

    localparam logic [Q_W-1:0] SIN_QUARTER [0:DEG_QUARTER] = '{
        15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,  15'd1428,  15'd1713,
        15'd1997,  15'd2280,  15'd2563,  15'd2845,  15'd3126,  15'd3406,  15'd3686,
        15'd3964,  15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,  15'd5604,
        15'd5872,  15'd6138,  15'd6402,  15'd6664,  15'd6924,  15'd7182,  15'd7438,
        15'd7692,  15'd7943,  15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
        15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311, 15'd10531, 15'd10749,
        15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
        15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421,
        15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466,
        15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
        15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897,
        15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262,
        15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
    };

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_DIR     = 9'b000000010,
        S_START_X = 9'b000000100,
        S_START_Y = 9'b000001000,
        S_STEP    = 9'b000010000,
        S_ADDR    = 9'b000100000,
        S_READ    = 9'b001000000,
        S_NEXT    = 9'b010000000,
        S_FINISH  = 9'b100000000
    } state_t;

    // sin of an angle below one full turn, from the quarter-wave table
    function automatic logic signed [DIR_W-1:0] sin_q14(input logic [DEG_W-1:0] d);
        logic [QIDX_W-1:0] r;
        logic              neg;
        priority if (d < DEG_W'(DEG_QUARTER))
        begin
            r   = QIDX_W'(d);
            neg = 1'b0;
        end
        else if (d < DEG_W'(2 * DEG_QUARTER))
        begin
            r   = QIDX_W'(DEG_W'(2 * DEG_QUARTER) - d);
            neg = 1'b0;
        end
        else if (d < DEG_W'(3 * DEG_QUARTER))
        begin
            r   = QIDX_W'(d - DEG_W'(2 * DEG_QUARTER));
            neg = 1'b1;
        end
        else
        begin
            r   = QIDX_W'(DEG_W'(DEG_FULL) - d);
            neg = 1'b1;
        end
        return neg ? -DIR_W'(SIN_QUARTER[r]) : DIR_W'(SIN_QUARTER[r]);
    endfunction

endpackage

### sv/rfes_ram.sv
module rfes_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/radial_farthest_edge_search_core.sv
// Farthest edge search over a binary edge image.
// Pixel channel (in_valid/in_stall, is_edge, last_pixel): one beat per pixel in
// raster order, one beat per cycle while the block is loading. The beat with
// last_pixel set starts the ray search; in_stall stays high until the result is loaded.
// Result channel (out_valid/out_stall): one beat per frame carrying found,
// hit_row, hit_col and hit_distance_sq; held in an output register, so pixel
// loading of the next frame carries on while a result waits.
// Search: 36 rays, each set up in S_DIR (table lookup), S_START_X and S_START_Y
// (start point through one shared multiplier) and closed in S_NEXT; each step
// inside the image goes through S_STEP (advance), S_ADDR (address) and S_READ
// (registered image memory read), and the step that leaves it skips S_READ.
// The memory read port sets the step. S_FINISH loads the result register.
// If the receiver stalls when the search ends, the block waits in its final
// state until the previous result beat is taken.
// cfg_valid/cfg_ready writes start_distance; ready is always high.
// Reset clears the pixel counter, the best hit and sets start_distance to 50.
// The image memory is not cleared; pixels a frame does not write keep old contents.
`include "radial_farthest_edge_search_core_macros.svh"

module radial_farthest_edge_search_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            is_edge,
    input  logic                            last_pixel,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            found,
    output logic [rfes_pkg::ROW_W-1:0]      hit_row,
    output logic [rfes_pkg::COL_W-1:0]      hit_col,
    output logic [rfes_pkg::DIST_OUT_W-1:0] hit_distance_sq,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rfes_pkg::SD_W-1:0]       cfg_data
);

    import rfes_pkg::*;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]        pix_cnt_reg, pix_cnt_next;
    logic [SD_W-1:0]         sd_reg;
    logic [DEG_W-1:0]        deg_reg, deg_next;
    logic signed [DIR_W-1:0] dx_reg, dx_next, dy_reg, dy_next;
    logic signed [POS_W-1:0] x_reg, x_next, y_reg, y_next;
    logic [ROW_W-1:0]        row_reg, row_next;
    logic [COL_W-1:0]        col_reg, col_next;

    logic [SQ_W-1:0]  best_d2_reg, best_d2_next;
    logic [ROW_W-1:0] best_row_reg, best_row_next;
    logic [COL_W-1:0] best_col_reg, best_col_next;
    logic             best_valid_reg, best_valid_next;

    logic                  out_valid_reg, out_valid_next;
    logic                  found_reg, found_next;
    logic [ROW_W-1:0]      hit_row_reg, hit_row_next;
    logic [COL_W-1:0]      hit_col_reg, hit_col_next;
    logic [DIST_OUT_W-1:0] hit_d2_reg, hit_d2_next;

    logic                      in_accept;
    logic                      ram_we;
    logic [ADDR_W-1:0]         ram_raddr;
    logic                      ram_rdata;
    logic [DEG_W-1:0]          deg_plus, cos_deg, deg_step;
    logic                      last_ray;
    logic signed [DIR_W-1:0]   mul_dir;
    logic signed [DIR_W+SD_W:0] mul_prod;
    logic signed [POS_W-1:0]   centre_q, start_pos;
    logic                      x_neg, y_neg, x_in, y_in;
    logic [IP_W-1:0]           x_int, y_int;
    logic [ROW_W-1:0]          row_c;
    logic [COL_W-1:0]          col_c;
    logic [ROW_W-1:0]          er_mag;
    logic [COL_W-1:0]          ec_mag;
    logic [SQ_W-1:0]           d2;

    assign in_accept = in_valid && (state_reg == S_IDLE);
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    assign out_valid       = out_valid_reg;
    assign found           = found_reg;
    assign hit_row         = hit_row_reg;
    assign hit_col         = hit_col_reg;
    assign hit_distance_sq = hit_d2_reg;

    // drop pixels past the end of an overlong frame
    assign ram_we = in_accept && (pix_cnt_reg < CNT_W'(PIX_TOTAL));

    rfes_ram #(
        .WIDTH (1),
        .DEPTH (PIX_TOTAL)
    ) u_image (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pix_cnt_reg[ADDR_W-1:0]),
        .wdata (is_edge),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign deg_plus = deg_reg + DEG_W'(DEG_QUARTER);
    assign cos_deg  = (deg_plus >= DEG_W'(DEG_FULL)) ? deg_plus - DEG_W'(DEG_FULL) : deg_plus;
    assign deg_step = deg_reg + DEG_W'(ANGLE_STEP_DEG);
    assign last_ray = (deg_step >= DEG_W'(DEG_FULL));

    // shared multiplier: x start in one cycle, y start in the next
    assign mul_dir   = (state_reg == S_START_Y) ? dy_reg : dx_reg;
    assign mul_prod  = mul_dir * $signed({1'b0, sd_reg});
    assign centre_q  = (state_reg == S_START_Y) ? CY_Q : CX_Q;
    assign start_pos = centre_q + POS_W'(mul_prod);

    // truncate toward zero: anything just below zero maps to index 0
    assign x_neg = x_reg[POS_W-1];
    assign y_neg = y_reg[POS_W-1];
    assign x_int = x_reg[POS_W-1:FRAC_BITS];
    assign y_int = y_reg[POS_W-1:FRAC_BITS];
    assign x_in  = x_neg ? (x_reg > NEG_LIMIT) : (x_int < IP_W'(IMAGE_WIDTH));
    assign y_in  = y_neg ? (y_reg > NEG_LIMIT) : (y_int < IP_W'(IMAGE_HEIGHT));
    assign col_c = x_neg ? '0 : x_int[COL_W-1:0];
    assign row_c = y_neg ? '0 : y_int[ROW_W-1:0];

    assign ram_raddr = ADDR_W'(row_c) * ADDR_W'(IMAGE_WIDTH) + ADDR_W'(col_c);

    assign er_mag = (row_reg >= ROW_W'(CY)) ? row_reg - ROW_W'(CY) : ROW_W'(CY) - row_reg;
    assign ec_mag = (col_reg >= COL_W'(CX)) ? col_reg - COL_W'(CX) : COL_W'(CX) - col_reg;
    assign d2     = SQ_W'(er_mag) * SQ_W'(er_mag) + SQ_W'(ec_mag) * SQ_W'(ec_mag);

    always_comb
    begin
        state_next      = state_reg;
        pix_cnt_next    = pix_cnt_reg;
        deg_next        = deg_reg;
        dx_next         = dx_reg;
        dy_next         = dy_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        best_d2_next    = best_d2_reg;
        best_row_next   = best_row_reg;
        best_col_next   = best_col_reg;
        best_valid_next = best_valid_reg;
        out_valid_next  = out_valid_reg && out_stall;
        found_next      = found_reg;
        hit_row_next    = hit_row_reg;
        hit_col_next    = hit_col_reg;
        hit_d2_next     = hit_d2_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (ram_we)
                    begin
                        pix_cnt_next = pix_cnt_reg + CNT_W'(1);
                    end
                    if (last_pixel)
                    begin
                        pix_cnt_next    = '0;
                        deg_next        = '0;
                        best_d2_next    = '0;
                        best_row_next   = '0;
                        best_col_next   = '0;
                        best_valid_next = 1'b0;
                        state_next      = S_DIR;
                    end
                end
            end
            S_DIR:
            begin
                dx_next    = sin_q14(cos_deg);
                dy_next    = sin_q14(deg_reg);
                state_next = S_START_X;
            end
            S_START_X:
            begin
                x_next     = start_pos;
                state_next = S_START_Y;
            end
            S_START_Y:
            begin
                y_next     = start_pos;
                state_next = S_STEP;
            end
            S_STEP:
            begin
                x_next     = x_reg + POS_W'(dx_reg);
                y_next     = y_reg + POS_W'(dy_reg);
                state_next = S_ADDR;
            end
            S_ADDR:
            begin
                row_next = row_c;
                col_next = col_c;
                if (x_in && y_in)
                begin
                    state_next = S_READ;
                end
                else
                begin
                    state_next = S_NEXT;
                end
            end
            S_READ:
            begin
                if (ram_rdata)
                begin
                    // strict compare: earlier ray keeps a tie, centre hit never counts
                    if (d2 > best_d2_reg)
                    begin
                        best_d2_next    = d2;
                        best_row_next   = row_reg;
                        best_col_next   = col_reg;
                        best_valid_next = 1'b1;
                    end
                    state_next = S_NEXT;
                end
                else
                begin
                    state_next = S_STEP;
                end
            end
            S_NEXT:
            begin
                if (last_ray)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    deg_next   = deg_step;
                    state_next = S_DIR;
                end
            end
            S_FINISH:
            begin
                // hold until the previous result beat has gone
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    found_next     = best_valid_reg;
                    hit_row_next   = best_row_reg;
                    hit_col_next   = best_col_reg;
                    hit_d2_next    = best_d2_reg[DIST_OUT_W-1:0];
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pix_cnt_reg    <= '0;
            sd_reg         <= SD_RESET;
            deg_reg        <= '0;
            best_d2_reg    <= '0;
            best_row_reg   <= '0;
            best_col_reg   <= '0;
            best_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pix_cnt_reg    <= pix_cnt_next;
            deg_reg        <= deg_next;
            best_d2_reg    <= best_d2_next;
            best_row_reg   <= best_row_next;
            best_col_reg   <= best_col_next;
            best_valid_reg <= best_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                sd_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        row_reg     <= row_next;
        col_reg     <= col_next;
        found_reg   <= found_next;
        hit_row_reg <= hit_row_next;
        hit_col_reg <= hit_col_next;
        hit_d2_reg  <= hit_d2_next;
    end

    `RFES_ASSERT_IMP(a_read_after_addr, state_reg == S_READ, $past(state_reg == S_ADDR), "memory read without an address cycle")
    `RFES_ASSERT_IMP(a_best_nonzero, best_valid_reg, best_d2_reg != '0, "recorded hit has zero distance")
    `RFES_ASSERT_IMP(a_best_inside, best_valid_reg, (best_row_reg < ROW_W'(IMAGE_HEIGHT)) && (best_col_reg < COL_W'(IMAGE_WIDTH)), "recorded hit outside the image")
    `RFES_ASSERT_IMP(a_not_found_zero, out_valid_reg && !found_reg, (hit_row_reg == '0) && (hit_col_reg == '0) && (hit_d2_reg == '0), "empty result carries a position")
    `RFES_ASSERT_NXT(a_search_clears_count, in_accept && last_pixel, pix_cnt_reg == '0 && state_reg == S_DIR, "search start did not rewind the pixel count")

endmodule

### tb/tb_radial_farthest_edge_search_core.sv
module tb_radial_farthest_edge_search_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROW_W      = rfes_pkg::ROW_W;
    localparam int COL_W      = rfes_pkg::COL_W;
    localparam int DIST_OUT_W = rfes_pkg::DIST_OUT_W;
    localparam int SD_W       = rfes_pkg::SD_W;

    localparam int IMG_W      = 188;
    localparam int IMG_H      = 120;
    localparam int PIX_TOTAL  = IMG_W * IMG_H;
    localparam int CENTRE_ROW = IMG_H / 2;
    localparam int CENTRE_COL = IMG_W / 2;
    localparam int CENTRE_IDX = CENTRE_ROW * IMG_W + CENTRE_COL;
    localparam int FRAC       = 14;
    localparam int RAYS       = 36;
    localparam int RAYS_PER_QUADRANT = 9;

    localparam int START_DIST_RESET = 50;
    localparam int HOLD_CYCLES      = 15000;
    localparam int PHASES           = 3;
    localparam int FRAMES_PER_PHASE = 14;
    localparam int RUN_LIMIT_NS     = 100_000_000;

    // sine of 0, 10, ... 90 degrees in Q2.14
    localparam int SIN_TENS [0:RAYS_PER_QUADRANT] = '{
        0, 2845, 5604, 8192, 10531, 12551, 14189, 15396, 16135, 16384
    };

    typedef struct packed {
        logic                  found;
        logic [ROW_W-1:0]      row;
        logic [COL_W-1:0]      col;
        logic [DIST_OUT_W-1:0] dist_sq;
    } far_hit_t;

    class edge_search_scoreboard;
        bit          frame_px [PIX_TOTAL];
        int unsigned px_count;
        int          ray_offset;
        far_hit_t    hits_due [$];
        int          errors;
        int          results_seen;

        function new();
            px_count     = 0;
            ray_offset   = START_DIST_RESET;
            errors       = 0;
            results_seen = 0;
        endfunction

        // sine of 10*k degrees
        function int sin_tenth(int k);
            int q;
            int r;
            q = (k % RAYS) / RAYS_PER_QUADRANT;
            r = (k % RAYS) % RAYS_PER_QUADRANT;
            case (q)
                0:       return SIN_TENS[r];
                1:       return SIN_TENS[RAYS_PER_QUADRANT - r];
                2:       return -SIN_TENS[r];
                default: return -SIN_TENS[RAYS_PER_QUADRANT - r];
            endcase
        endfunction

        // truncate toward zero
        function int to_whole(int v);
            if (v >= 0)
                return v >>> FRAC;
            return -((-v) >>> FRAC);
        endfunction

        function far_hit_t farthest_hit();
            far_hit_t best;
            int       best_d2;
            int       dx, dy, x, y, row, col, d2;
            best    = '0;
            best_d2 = 0;
            for (int k = 0; k < RAYS; k++)
            begin
                dx = sin_tenth(k + RAYS_PER_QUADRANT);
                dy = sin_tenth(k);
                x  = (CENTRE_COL << FRAC) + dx * ray_offset;
                y  = (CENTRE_ROW << FRAC) + dy * ray_offset;
                while (1)
                begin
                    x   = x + dx;
                    y   = y + dy;
                    row = to_whole(y);
                    col = to_whole(x);
                    if (row < 0 || row >= IMG_H || col < 0 || col >= IMG_W)
                        break;
                    if (frame_px[row * IMG_W + col])
                    begin
                        d2 = (row - CENTRE_ROW) * (row - CENTRE_ROW)
                           + (col - CENTRE_COL) * (col - CENTRE_COL);
                        // a hit on the centre stops the ray but never counts
                        if (d2 > best_d2)
                        begin
                            best_d2      = d2;
                            best.found   = 1'b1;
                            best.row     = row[ROW_W-1:0];
                            best.col     = col[COL_W-1:0];
                            best.dist_sq = d2[DIST_OUT_W-1:0];
                        end
                        break;
                    end
                end
            end
            return best;
        endfunction

        function void note_pixel(bit px_edge, bit px_last);
            // drop pixels past a full frame
            if (px_count < PIX_TOTAL)
            begin
                frame_px[px_count] = px_edge;
                px_count++;
            end
            if (px_last)
            begin
                hits_due.push_back(farthest_hit());
                px_count = 0;
            end
        endfunction

        function void flag(string what, int want, int got);
            errors++;
            if (errors <= 10)
                $display("result %0d: %s expected %0d, got %0d", results_seen, what, want, got);
        endfunction

        function void check_result(far_hit_t got);
            far_hit_t want;
            results_seen++;
            if (hits_due.size() == 0)
            begin
                flag("unexpected beat, found", 0, got.found);
                return;
            end
            want = hits_due.pop_front();
            if (got.found !== want.found)
                flag("found", want.found, got.found);
            if (got.row !== want.row)
                flag("hit_row", want.row, got.row);
            if (got.col !== want.col)
                flag("hit_col", want.col, got.col);
            if (got.dist_sq !== want.dist_sq)
                flag("hit_distance_sq", want.dist_sq, got.dist_sq);
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  is_edge = 1'b0;
    logic                  last_pixel = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  found;
    logic [ROW_W-1:0]      hit_row;
    logic [COL_W-1:0]      hit_col;
    logic [DIST_OUT_W-1:0] hit_distance_sq;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [SD_W-1:0]       cfg_data = '0;

    edge_search_scoreboard sb = new();

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    bit          hold_req = 1'b0;

    int unsigned edge_odds [5] = '{0, 2, 8, 40, 300};

    radial_farthest_edge_search_core i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .is_edge         (is_edge),
        .last_pixel      (last_pixel),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .found           (found),
        .hit_row         (hit_row),
        .hit_col         (hit_col),
        .hit_distance_sq (hit_distance_sq),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("*** FAILED ***");
        $finish;
    end

    // result side: take beats, stall at random or hold off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && !out_stall)
                sb.check_result({found, hit_row, hit_col, hit_distance_sq});
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(99, 0) < recv_idle_pct);
        end
    end

    task automatic send_pixel(bit px_edge, bit px_last);
        in_valid   <= 1'b1;
        is_edge    <= px_edge;
        last_pixel <= px_last;
        do @(posedge clk); while (in_stall);
        sb.note_pixel(px_edge, px_last);
        if ($urandom_range(99, 0) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
    endtask

    // odds 0 gives an empty frame, otherwise one edge in odds on average
    task automatic send_frame(int unsigned len, int unsigned odds, bit mark_centre);
        bit px_edge;
        for (int unsigned p = 0; p < len; p++)
        begin
            px_edge = (odds != 0) && ($urandom_range(odds - 1, 0) == 0);
            if (mark_centre && p == CENTRE_IDX)
                px_edge = 1'b1;
            send_pixel(px_edge, p == len - 1);
        end
    endtask

    task automatic wait_results_in();
        in_valid <= 1'b0;
        while (sb.hits_due.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_start_distance(logic [SD_W-1:0] offset_val);
        cfg_valid <= 1'b1;
        cfg_data  <= offset_val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid     <= 1'b0;
        sb.ray_offset = offset_val;
        @(posedge clk);
    endtask

    function automatic logic [SD_W-1:0] pick_start_distance();
        case ($urandom_range(9, 0))
            0:       return '0;
            1:       return '1;
            2, 3:    return SD_W'($urandom_range(255, 0));
            default: return SD_W'($urandom_range(110, 0));
        endcase
    endfunction

    function automatic int unsigned pick_short_len();
        int unsigned pick;
        pick = $urandom_range(9, 0);
        if (pick < 7)
            return $urandom_range(8, 1);
        if (pick < 9)
            return $urandom_range(40, 9);
        return $urandom_range(150, 41);
    endfunction

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 35;
        recv_idle_pct = 52;

        // overlong first frame fills the whole image at the reset distance
        send_frame(PIX_TOTAL + 7, 40, 1'b1);
        wait_results_in();
        // rays that first land on the marked centre stop without a hit
        write_start_distance('0);
        send_frame(1, 1, 1'b0);
        wait_results_in();
        write_start_distance('1);
        send_frame(2, 2, 1'b0);
        wait_results_in();
        write_start_distance(SD_W'(1));
        send_frame(4, 2, 1'b0);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct = 35;
                    recv_idle_pct = 52;
                end
                1:
                begin
                    send_idle_pct = 52;
                    recv_idle_pct = 35;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int f = 0; f < FRAMES_PER_PHASE; f++)
            begin
                if (f % 4 == 0)
                begin
                    wait_results_in();
                    write_start_distance(pick_start_distance());
                end
                send_frame(pick_short_len(), edge_odds[$urandom_range(4, 0)], 1'b0);
            end

            // hold off the result side so the block fills up and stalls pixels
            if (ph == 1)
            begin
                wait_results_in();
                write_start_distance(SD_W'(60));
                hold_req = 1'b1;
                repeat (3)
                    send_frame($urandom_range(30, 1), 8, 1'b0);
            end
        end

        wait_results_in();
        repeat (100) @(posedge clk);
        if (sb.errors == 0 && sb.hits_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
